### src/scrag_pkg.sv
// shared types and microcode rom for the sprite clip row address generator
// used by scrag_seq and sprite_clip_row_address_gen_top; no dependencies
package scrag_pkg;

  localparam int CW  = 13;
  localparam int AXW = 10;
  localparam int PCW = 3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [PCW-1:0] pc_t;

  // register indexes on the config port
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_HOTSPOT_X    = 3'd2;
  localparam logic [2:0] REG_HOTSPOT_Y    = 3'd3;
  localparam logic [2:0] REG_PLANE_BYTES  = 3'd4;
  localparam logic [2:0] REG_FRAME_VALID  = 3'd5;

  // program steps
  localparam pc_t PC_IDLE   = 3'd0;
  localparam pc_t PC_CHECK  = 3'd1;
  localparam pc_t PC_HCLIP  = 3'd2;
  localparam pc_t PC_PREP   = 3'd3;
  localparam pc_t PC_SHADD  = 3'd4;
  localparam pc_t PC_DST    = 3'd5;
  localparam pc_t PC_EMIT   = 3'd6;
  localparam pc_t PC_REJECT = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_CHECK  = 3'd1,
    OP_HCLIP  = 3'd2,
    OP_PREP   = 3'd3,
    OP_SHADD  = 3'd4,
    OP_DST    = 3'd5,
    OP_EMIT   = 3'd6,
    OP_REJECT = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    JC_NEXT = 2'd0,
    JC_GOTO = 2'd1,
    JC_COND = 2'd2,
    JC_HOLD = 2'd3
  } jc_t;

  typedef struct packed {
    op_t op;
    jc_t jc;
    pc_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t w;
    unique case (pc)
      PC_IDLE:   w = '{op: OP_LOAD,   jc: JC_HOLD, target: PC_CHECK};
      PC_CHECK:  w = '{op: OP_CHECK,  jc: JC_COND, target: PC_REJECT};
      PC_HCLIP:  w = '{op: OP_HCLIP,  jc: JC_NEXT, target: PC_IDLE};
      PC_PREP:   w = '{op: OP_PREP,   jc: JC_COND, target: PC_REJECT};
      PC_SHADD:  w = '{op: OP_SHADD,  jc: JC_NEXT, target: PC_IDLE};
      PC_DST:    w = '{op: OP_DST,    jc: JC_NEXT, target: PC_IDLE};
      PC_EMIT:   w = '{op: OP_EMIT,   jc: JC_HOLD, target: PC_IDLE};
      PC_REJECT: w = '{op: OP_REJECT, jc: JC_GOTO, target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

### src/sprite_clip_row_address_gen_top.sv
// sprite clip row address generator: config registers, datapath, output beat register
// depends on scrag_pkg and scrag_seq
// after accept: check, hclip, prep, shadd, dst, then emit gives one row beat per cycle
// (rows = visible rows, at most MAX_HEIGHT); a reject at check or prep gives one rejected beat
// the receiver cannot stall; one 12x12 multiplier is shared across the setup steps
// synchronous active-low reset clears the step counter and the strobe and sets the config registers to defaults
module sprite_clip_row_address_gen_top #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200,
  parameter int MAX_HEIGHT    = 64,
  parameter int MAX_GROUPS    = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [23:0]        in_screen_base,
  input  logic signed [10:0] in_pos_x,
  input  logic signed [10:0] in_pos_y,
  output logic               out_valid,
  output logic               out_rejected,
  output logic [24:0]        out_dst_addr,
  output logic [15:0]        out_src_offset,
  output logic [2:0]         out_group_count,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int HALF_W = SCREEN_WIDTH / 2;

  scrag_pkg::ctrl_t ctrl;
  logic             cond;

  // config registers
  logic [6:0]  fwidth_r, fheight_r, hotx_r;
  logic [5:0]  hoty_r;
  logic [11:0] psb_r;
  logic        fvalid_r;
  logic        wr_en;

  // datapath registers
  logic [23:0]       base_r, base_nxt;
  scrag_pkg::coord_t x_r, x_nxt, y_r, y_nxt;
  logic [10:0]       negy_r, negy_nxt;
  logic [6:0]        h_r, h_nxt, w_r, w_nxt;
  logic [3:0]        shift_r, shift_nxt;
  logic [scrag_pkg::AXW-1:0] ax_r, ax_nxt;
  logic [5:0]        pitch_r, pitch_nxt;
  logic [6:0]        srcx_r, srcx_nxt;
  logic [15:0]       src_r, src_nxt;
  logic [24:0]       dst_r, dst_nxt, dstep_r, dstep_nxt;
  logic [7:0]        sstep_r, sstep_nxt;
  logic [2:0]        grp_r, grp_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [11:0]       mul_a, mul_b;
  logic [23:0]       mul_r;

  // output beat register
  logic        ovalid_r, ovalid_nxt;
  logic        orej_r, orej_nxt;
  logic [24:0] odst_r, odst_nxt;
  logic [15:0] osrc_r, osrc_nxt;
  logic [2:0]  ogrp_r, ogrp_nxt;
  logic        olast_r, olast_nxt;

  // combinational helpers
  scrag_pkg::coord_t xw, yh, negx, axs, skip_in, wm, dw, dp, ds;
  logic [3:0]  skip;
  logic [5:0]  p5;
  logic [2:0]  groups;
  logic [6:0]  g5;
  logic        rej;
  logic        is_last;

  scrag_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // config port
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwidth_r  <= 7'd32;
      fheight_r <= 7'd16;
      hotx_r    <= 7'd16;
      hoty_r    <= 6'd8;
      psb_r     <= 12'd320;
      fvalid_r  <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        scrag_pkg::REG_FRAME_WIDTH:  fwidth_r  <= pwdata[6:0];
        scrag_pkg::REG_FRAME_HEIGHT: fheight_r <= pwdata[6:0];
        scrag_pkg::REG_HOTSPOT_X:    hotx_r    <= pwdata[6:0];
        scrag_pkg::REG_HOTSPOT_Y:    hoty_r    <= pwdata[5:0];
        scrag_pkg::REG_PLANE_BYTES:  psb_r     <= pwdata[11:0];
        scrag_pkg::REG_FRAME_VALID:  fvalid_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      scrag_pkg::REG_FRAME_WIDTH:  prdata = {25'd0, fwidth_r};
      scrag_pkg::REG_FRAME_HEIGHT: prdata = {25'd0, fheight_r};
      scrag_pkg::REG_HOTSPOT_X:    prdata = {25'd0, hotx_r};
      scrag_pkg::REG_HOTSPOT_Y:    prdata = {26'd0, hoty_r};
      scrag_pkg::REG_PLANE_BYTES:  prdata = {20'd0, psb_r};
      scrag_pkg::REG_FRAME_VALID:  prdata = {31'd0, fvalid_r};
      default:                     prdata = 32'd0;
    endcase
  end

  // shared arithmetic
  assign xw      = x_r + scrag_pkg::coord_t'(w_r);
  assign yh      = y_r + scrag_pkg::coord_t'(h_r);
  assign negx    = -x_r;
  assign axs     = {x_r[scrag_pkg::CW-1:4], 4'b0000};
  assign skip_in = x_r[scrag_pkg::CW-1] ? (negx + scrag_pkg::coord_t'(15))
                 : (axs + scrag_pkg::coord_t'(w_r) - scrag_pkg::coord_t'(SCREEN_WIDTH)
                    + scrag_pkg::coord_t'(15));
  assign skip    = skip_in[7:4];
  assign p5      = 6'({skip, 2'b00}) + 6'(skip);
  assign wm      = scrag_pkg::coord_t'(w_r) - negx;
  assign groups  = w_r[6:4];
  assign g5      = 7'({groups, 2'b00}) + 7'(groups) + 7'(pitch_r);
  assign dw      = scrag_pkg::coord_t'(SCREEN_WIDTH) - scrag_pkg::coord_t'(w_r);
  assign dp      = dw[scrag_pkg::CW-1] ? -((-dw + scrag_pkg::coord_t'(3)) >>> 2) : (dw >>> 2);
  assign ds      = scrag_pkg::coord_t'({groups, 3'b000}) + (dp <<< 1);
  assign rej     = !fvalid_r
                || (x_r > scrag_pkg::coord_t'(SCREEN_WIDTH - 1))
                || (y_r > scrag_pkg::coord_t'(SCREEN_HEIGHT - 1))
                || (xw <= scrag_pkg::coord_t'(0))
                || (yh <= scrag_pkg::coord_t'(0));
  assign is_last = (rem_r == RW'(1));

  always_comb begin
    base_nxt   = base_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    negy_nxt   = negy_r;
    h_nxt      = h_r;
    w_nxt      = w_r;
    shift_nxt  = shift_r;
    ax_nxt     = ax_r;
    pitch_nxt  = pitch_r;
    srcx_nxt   = srcx_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    dstep_nxt  = dstep_r;
    sstep_nxt  = sstep_r;
    grp_nxt    = grp_r;
    rem_nxt    = rem_r;
    mul_a      = 12'd0;
    mul_b      = 12'd0;
    cond       = 1'b0;
    ovalid_nxt = 1'b0;
    orej_nxt   = orej_r;
    odst_nxt   = odst_r;
    osrc_nxt   = osrc_r;
    ogrp_nxt   = ogrp_r;
    olast_nxt  = olast_r;
    unique case (ctrl.op)
      scrag_pkg::OP_LOAD: begin
        cond     = start;
        base_nxt = in_screen_base;
        x_nxt    = scrag_pkg::coord_t'(in_pos_x) - scrag_pkg::coord_t'(hotx_r);
        y_nxt    = scrag_pkg::coord_t'(in_pos_y) - scrag_pkg::coord_t'(hoty_r);
        w_nxt    = fwidth_r;
        h_nxt    = fheight_r;
      end
      scrag_pkg::OP_CHECK: begin
        cond = rej;
        if (y_r[scrag_pkg::CW-1]) begin
          negy_nxt = 11'(-y_r);
          h_nxt    = 7'(yh);
          y_nxt    = '0;
        end else begin
          negy_nxt = '0;
          if (yh > scrag_pkg::coord_t'(SCREEN_HEIGHT)) begin
            h_nxt = 7'(scrag_pkg::coord_t'(SCREEN_HEIGHT) - y_r);
          end
        end
      end
      scrag_pkg::OP_HCLIP: begin
        shift_nxt = x_r[3:0];
        mul_a     = 12'({w_r, 2'b00}) + 12'(w_r);
        mul_b     = 12'(negy_r);
        if (x_r[scrag_pkg::CW-1]) begin
          w_nxt     = {wm[6:4], 4'b0000};
          pitch_nxt = p5;
          srcx_nxt  = {p5, 1'b0};
          ax_nxt    = '0;
        end else if (xw - scrag_pkg::coord_t'(x_r[3:0])
                     > scrag_pkg::coord_t'(SCREEN_WIDTH)) begin
          w_nxt     = 7'(scrag_pkg::coord_t'(SCREEN_WIDTH) - axs);
          pitch_nxt = p5;
          srcx_nxt  = '0;
          ax_nxt    = scrag_pkg::AXW'(axs);
        end else begin
          pitch_nxt = '0;
          srcx_nxt  = '0;
          ax_nxt    = scrag_pkg::AXW'(axs);
        end
      end
      scrag_pkg::OP_PREP: begin
        cond      = (h_r == 7'd0);
        src_nxt   = mul_r[18:3] + 16'(srcx_r);
        grp_nxt   = ({1'b0, groups} > 4'(MAX_GROUPS)) ? 3'(MAX_GROUPS) : groups;
        dstep_nxt = 25'(ds);
        sstep_nxt = {g5, 1'b0};
        rem_nxt   = (h_r > 7'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(h_r);
        mul_a     = 12'(shift_r);
        mul_b     = psb_r;
      end
      scrag_pkg::OP_SHADD: begin
        src_nxt = src_r + mul_r[15:0];
        mul_a   = 12'(y_r);
        mul_b   = 12'(HALF_W);
      end
      scrag_pkg::OP_DST: begin
        dst_nxt = 25'(base_r) + 25'(ax_r >> 1) + 25'(mul_r);
      end
      scrag_pkg::OP_EMIT: begin
        cond       = is_last;
        ovalid_nxt = 1'b1;
        orej_nxt   = 1'b0;
        odst_nxt   = dst_r;
        osrc_nxt   = src_r;
        ogrp_nxt   = grp_r;
        olast_nxt  = is_last;
        dst_nxt    = dst_r + dstep_r;
        src_nxt    = src_r + 16'(sstep_r);
        rem_nxt    = rem_r - RW'(1);
      end
      scrag_pkg::OP_REJECT: begin
        ovalid_nxt = 1'b1;
        orej_nxt   = 1'b1;
        odst_nxt   = '0;
        osrc_nxt   = '0;
        ogrp_nxt   = '0;
        olast_nxt  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    negy_r  <= negy_nxt;
    h_r     <= h_nxt;
    w_r     <= w_nxt;
    shift_r <= shift_nxt;
    ax_r    <= ax_nxt;
    pitch_r <= pitch_nxt;
    srcx_r  <= srcx_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    dstep_r <= dstep_nxt;
    sstep_r <= sstep_nxt;
    grp_r   <= grp_nxt;
    rem_r   <= rem_nxt;
    mul_r   <= mul_a * mul_b;
    orej_r  <= orej_nxt;
    odst_r  <= odst_nxt;
    osrc_r  <= osrc_nxt;
    ogrp_r  <= ogrp_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_rejected    = orej_r;
  assign out_dst_addr    = odst_r;
  assign out_src_offset  = osrc_r;
  assign out_group_count = ogrp_r;
  assign out_last        = olast_r;

endmodule

### src/scrag_seq.sv
// step counter and control word fetch for the sprite clip row address generator
// depends on scrag_pkg for the control word type and the microcode rom
module scrag_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cond,
  output scrag_pkg::ctrl_t  ctrl,
  output logic              busy
);

  scrag_pkg::pc_t pc_r;
  scrag_pkg::pc_t pc_nxt;
  scrag_pkg::pc_t pc_inc;

  assign ctrl   = scrag_pkg::ucode(pc_r);
  assign pc_inc = pc_r + scrag_pkg::pc_t'(1);
  assign busy   = (pc_r != scrag_pkg::PC_IDLE);

  always_comb begin
    unique case (ctrl.jc)
      scrag_pkg::JC_NEXT: pc_nxt = pc_inc;
      scrag_pkg::JC_GOTO: pc_nxt = ctrl.target;
      scrag_pkg::JC_COND: pc_nxt = cond ? ctrl.target : pc_inc;
      scrag_pkg::JC_HOLD: pc_nxt = cond ? ctrl.target : pc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= scrag_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
